// ===== sv/sgts_pkg.sv =====
// ----------------------------------------------------------------------------
// sgts_pkg: shared types and constants of the silence gap track splitter
// sample and counter widths, register indexes, the word passed front to back
// ----------------------------------------------------------------------------
package sgts_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 32;
   localparam int ENERGY_BITS = 2 * SAMPLE_BITS;

   localparam int THRESH_BITS = 32;
   localparam int GAP_BITS    = 24;
   localparam int TRACK_BITS  = 16;
   localparam int TIME_BITS   = 32;
   localparam int MINTRK_BITS = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   // compare widths wide enough for both sides
   localparam int LOUD_CMP_BITS = (ENERGY_BITS > THRESH_BITS) ? ENERGY_BITS : THRESH_BITS;
   localparam int CMP_BITS      = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOUD_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_SILENCE  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_GAP        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_TRACK      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPORT_CUTS    = 3'd4;

   // register reset values
   localparam logic [THRESH_BITS-1:0] LOUD_THRESHOLD_RESET = 32'd428441;
   localparam logic [GAP_BITS-1:0]    SHORT_SILENCE_RESET  = 24'd8820;
   localparam logic [GAP_BITS-1:0]    MIN_GAP_RESET        = 24'd44102;
   localparam logic [MINTRK_BITS-1:0] MIN_TRACK_RESET      = 32'd88203;

   // one classified sample word
   typedef struct packed {
      logic loud;
      logic last;
   } sgts_word_type;

   // register file seen by the back part
   typedef struct packed {
      logic [GAP_BITS-1:0]    short_silence;
      logic [GAP_BITS-1:0]    min_gap;
      logic [MINTRK_BITS-1:0] min_track;
      logic                   report_cuts;
   } sgts_back_cfg_type;

endpackage

// ===== sv/sgts_front.sv =====
// ----------------------------------------------------------------------------
// sgts_front: sample classifier
// squares both channels in one stage, sums and compares against the loud
// threshold from its registers, and pushes a loud/last word into the queue
// ----------------------------------------------------------------------------
module sgts_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [sgts_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [sgts_pkg::SAMPLE_BITS-1:0] req_right_sample,
   input  logic                                req_last_sample,
   input  logic [sgts_pkg::THRESH_BITS-1:0]    loud_threshold,
   output logic                                stage_busy,
   output logic                                push_valid,
   output sgts_pkg::sgts_word_type             push_word
);
   import sgts_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   logic [ENERGY_BITS-1:0] sq_left_ff, sq_left_in;
   logic [ENERGY_BITS-1:0] sq_right_ff, sq_right_in;
   logic                   s1_last_ff;
   logic [SAMPLE_BITS-1:0] mag_left, mag_right;
   logic [ENERGY_BITS-1:0] energy;
   logic                   take;

   assign take = req_valid && !req_stall;

   // magnitude of the most negative code wraps to the right unsigned value
   always_comb begin
      mag_left  = req_left_sample[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-req_left_sample)
                                                  : SAMPLE_BITS'(req_left_sample);
      mag_right = req_right_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-req_right_sample)
                                                  : SAMPLE_BITS'(req_right_sample);
      sq_left_in  = ENERGY_BITS'(mag_left) * ENERGY_BITS'(mag_left);
      sq_right_in = ENERGY_BITS'(mag_right) * ENERGY_BITS'(mag_right);
      s1_valid_in = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         sq_left_ff  <= sq_left_in;
         sq_right_ff <= sq_right_in;
         s1_last_ff  <= req_last_sample;
      end
   end

   // sum of two squares never exceeds 2^(2*SAMPLE_BITS-1)
   assign energy         = sq_left_ff + sq_right_ff;
   assign push_valid     = s1_valid_ff;
   assign push_word.loud = LOUD_CMP_BITS'(energy) >= LOUD_CMP_BITS'(loud_threshold);
   assign push_word.last = s1_last_ff;
   assign stage_busy     = s1_valid_ff;

endmodule

// ===== sv/sgts_queue.sv =====
// ----------------------------------------------------------------------------
// sgts_queue: short word queue between classifier and run tracker
// register array with read and write pointers and a fill count
// ----------------------------------------------------------------------------
module sgts_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  sgts_pkg::sgts_word_type       push_word,
   input  logic                          pop,
   output logic                          pop_valid,
   output sgts_pkg::sgts_word_type       pop_word,
   output logic [sgts_pkg::QCNT_BITS-1:0] fill_count
);
   import sgts_pkg::*;

   sgts_word_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign pop_valid  = count_ff != '0;
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign fill_count = count_ff;

endmodule

// ===== sv/sgts_back.sv =====
// ----------------------------------------------------------------------------
// sgts_back: quiet run tracker and track reporter
// keeps run length, position, previous cut and track count, one word a cycle
// unless stalled, and holds at most one pending result in the output register
// ----------------------------------------------------------------------------
module sgts_back (
   input  logic                                clock,
   input  logic                                reset,
   input  sgts_pkg::sgts_back_cfg_type         cfg,
   input  logic                                pop_valid,
   input  sgts_pkg::sgts_word_type             pop_word,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sgts_pkg::TRACK_BITS-1:0]     rsp_track_number,
   output logic [sgts_pkg::TIME_BITS-1:0]      rsp_time_samples
);
   import sgts_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [TRACK_BITS-1:0] TRACK_MAX = '1;
   localparam logic [CMP_BITS-1:0]   TIME_MAX  = CMP_BITS'({TIME_BITS{1'b1}});

   logic [COUNT_BITS-1:0] quiet_ff, quiet_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [COUNT_BITS-1:0] prev_ff, prev_in;
   logic [TRACK_BITS-1:0] track_ff, track_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TRACK_BITS-1:0] rsp_track_ff, rsp_track_in;
   logic [TIME_BITS-1:0]  rsp_time_ff, rsp_time_in;

   logic [COUNT_BITS-1:0] gap;
   logic [COUNT_BITS-1:0] quiet_step;
   logic [COUNT_BITS-1:0] pos_step;
   logic [COUNT_BITS-1:0] cut_pos;
   logic [COUNT_BITS-1:0] dur;
   logic [CMP_BITS-1:0]   report_wide;
   logic                  loud_cut, trail_cut, cut, emit;

   // output slot free or draining this cycle
   assign pop = pop_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      // a zero gap acts as one
      gap = (cfg.min_gap == '0) ? COUNT_BITS'(1) : COUNT_BITS'(cfg.min_gap);

      loud_cut = pop_word.loud
               && (CMP_BITS'(quiet_ff) > CMP_BITS'(cfg.short_silence))
               && (quiet_ff >= gap);

      if (pop_word.loud) begin
         quiet_step = '0;
      end else if (quiet_ff != COUNT_MAX) begin
         quiet_step = quiet_ff + 1'b1;
      end else begin
         quiet_step = quiet_ff;
      end
      pos_step = (pos_ff != COUNT_MAX) ? pos_ff + 1'b1 : pos_ff;

      // trailing run includes the last sample, cut lies after it
      trail_cut = pop_word.last && !loud_cut && (quiet_step >= gap);
      cut       = loud_cut || trail_cut;
      cut_pos   = loud_cut ? pos_ff : pos_step;
      dur       = cut_pos - prev_ff;
      emit      = cut && (CMP_BITS'(dur) >= CMP_BITS'(cfg.min_track));

      track_in  = (emit && track_ff != TRACK_MAX) ? track_ff + 1'b1 : track_ff;
      quiet_in  = quiet_step;
      pos_in    = pos_step;
      prev_in   = cut ? cut_pos : prev_ff;

      report_wide = cfg.report_cuts ? CMP_BITS'(cut_pos) : CMP_BITS'(dur);
      rsp_track_in = track_in;
      rsp_time_in  = (report_wide > TIME_MAX) ? {TIME_BITS{1'b1}}
                                               : TIME_BITS'(report_wide);

      // end of stream puts the run state back to its start
      if (pop_word.last) begin
         quiet_in = '0;
         pos_in   = '0;
         prev_in  = '0;
         track_in = '0;
      end

      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff     <= '0;
         pos_ff       <= '0;
         prev_ff      <= '0;
         track_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            quiet_ff <= quiet_in;
            pos_ff   <= pos_in;
            prev_ff  <= prev_in;
            track_ff <= track_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop && emit) begin
         rsp_track_ff <= rsp_track_in;
         rsp_time_ff  <= rsp_time_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_track_number = rsp_track_ff;
   assign rsp_time_samples = rsp_time_ff;

endmodule

// ===== sv/silence_gap_track_splitter.sv =====
// ----------------------------------------------------------------------------
// silence_gap_track_splitter: energy threshold silence detector and track cutter
// splits a stereo PCM word stream into tracks at long quiet runs
// ----------------------------------------------------------------------------
// One stereo sample word is taken per clock when the rsp side keeps up. An
// accepted word is squared into the classifier register; from there its sum
// and threshold compare are written into a four-entry queue, and the run
// tracker takes it, one word a cycle unless the output is stalled, loading
// any track result into the output register as it takes the word.
// The classifier throttles input by the queue fill plus the word in the
// square stage, so a stalled result side stops intake after a few words
// without losing any. A sample is loud when
// left^2 + right^2 reaches the loud threshold. A quiet run that ends on a
// loud sample makes a cut when it is longer than the short silence length
// and at least the minimum gap; on the word flagged last a trailing quiet
// run needs only the minimum gap. Each cut becomes the previous cut, and
// reports a track (number and either cut position or length) only when it
// lies at least min_track samples after the previous one. After the last
// word all run state clears; the registers keep their values. Registers are
// written through the csr port and must only be changed while idle.
// ----------------------------------------------------------------------------
module silence_gap_track_splitter (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample words in
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sgts_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [sgts_pkg::SAMPLE_BITS-1:0] req_right_sample,
   input  logic                                   req_last_sample,
   // track results out
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sgts_pkg::TRACK_BITS-1:0]        rsp_track_number,
   output logic [sgts_pkg::TIME_BITS-1:0]         rsp_time_samples,
   // register writes
   input  logic                                   csr_write_enable,
   input  logic [sgts_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sgts_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import sgts_pkg::*;

   // register file
   logic [THRESH_BITS-1:0] loud_threshold_ff;
   logic [GAP_BITS-1:0]    short_silence_ff;
   logic [GAP_BITS-1:0]    min_gap_ff;
   logic [MINTRK_BITS-1:0] min_track_ff;
   logic                   report_cuts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loud_threshold_ff <= LOUD_THRESHOLD_RESET;
         short_silence_ff  <= SHORT_SILENCE_RESET;
         min_gap_ff        <= MIN_GAP_RESET;
         min_track_ff      <= MIN_TRACK_RESET;
         report_cuts_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOUD_THRESHOLD: loud_threshold_ff <= THRESH_BITS'(csr_wdata);
            CSR_SHORT_SILENCE:  short_silence_ff  <= GAP_BITS'(csr_wdata);
            CSR_MIN_GAP:        min_gap_ff        <= GAP_BITS'(csr_wdata);
            CSR_MIN_TRACK:      min_track_ff      <= MINTRK_BITS'(csr_wdata);
            CSR_REPORT_CUTS:    report_cuts_ff    <= csr_wdata[0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   sgts_back_cfg_type back_cfg;
   assign back_cfg.short_silence = short_silence_ff;
   assign back_cfg.min_gap       = min_gap_ff;
   assign back_cfg.min_track     = min_track_ff;
   assign back_cfg.report_cuts   = report_cuts_ff;

   logic                  stage_busy;
   logic                  push_valid;
   sgts_word_type         push_word;
   logic                  pop;
   logic                  pop_valid;
   sgts_word_type         pop_word;
   logic [QCNT_BITS-1:0]  fill_count;
   logic [QCNT_BITS:0]    committed;

   // every word in the queue or in the classifier stage owns a queue slot,
   // so a push always finds room
   assign committed = (QCNT_BITS + 1)'(fill_count) + (QCNT_BITS + 1)'(stage_busy);
   assign req_stall = committed >= (QCNT_BITS + 1)'(QUEUE_DEPTH);

   sgts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_last_sample  (req_last_sample),
      .loud_threshold   (loud_threshold_ff),
      .stage_busy       (stage_busy),
      .push_valid       (push_valid),
      .push_word        (push_word)
   );

   sgts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .fill_count (fill_count)
   );

   sgts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (back_cfg),
      .pop_valid        (pop_valid),
      .pop_word         (pop_word),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_track_number (rsp_track_number),
      .rsp_time_samples (rsp_time_samples)
   );

endmodule
